// ----- hw/rtl/tbpg_pkg.sv -----
// shared types, constants and the 5x7 font table of the text band pixel generator
package tbpg_pkg;

  localparam int unsigned BAND_WIDTH = 320;
  localparam int unsigned BAND_ROWS  = 8;
  localparam int unsigned MAX_CHARS  = 64;
  localparam int unsigned CHAR_PITCH = 6;

  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned GLYPH_ROWS = 7;
  localparam int unsigned GLYPH_NUM  = 91;
  localparam logic [7:0]  FIRST_CODE = 8'h20;
  localparam logic [7:0]  LAST_CODE  = 8'h7A;

  localparam int unsigned COLOR_W = 16;
  localparam int unsigned COL_W   = 9;
  localparam int unsigned ROW_W   = 3;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned GX_W    = 3;
  localparam int unsigned ADDR_W  = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // column to cell split by multiplication with a scaled reciprocal of the pitch
  localparam int unsigned DIV_SHIFT = 18;
  localparam int unsigned RECIP_W   = 16;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((2 ** DIV_SHIFT + CHAR_PITCH - 1) / CHAR_PITCH);
  localparam int unsigned PROD_W = COL_W + RECIP_W;
  localparam int unsigned CELL_W = PROD_W - DIV_SHIFT;

  localparam logic [COLOR_W-1:0] FG_RESET     = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BG_RESET     = 16'h0000;
  localparam logic [ROW_W-1:0]   ROW_OFF_RESET = '0;
  localparam logic [COL_W-1:0]   MARGIN_RESET = 9'd10;
  localparam logic [LEN_W-1:0]   LENGTH_RESET = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FG_COLOR   = 3'd0,
    CFG_BG_COLOR   = 3'd1,
    CFG_ROW_OFFSET = 3'd2,
    CFG_MARGIN     = 3'd3,
    CFG_LENGTH     = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [ROW_W-1:0]   row_off;
    logic [COL_W-1:0]   margin;
    logic [LEN_W-1:0]   length;
  } cfg_t;

  typedef struct packed {
    logic              vld;
    logic              emit;
    logic [IDX_W-1:0]  idx;
    logic [CODE_W-1:0] code;
    logic [ADDR_W-1:0] addr;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              last;
    logic              draw;
    logic [GX_W-1:0]   gx;
    logic [ROW_W-1:0]  gy;
  } loc_t;

  typedef struct packed {
    logic               vld;
    logic [COLOR_W-1:0] color;
    logic [COL_W-1:0]   col;
    logic [ROW_W-1:0]   row;
    logic               last;
  } pix_t;

  // one entry per code, glyph columns 0..4 from the high byte down
  localparam logic [39:0] GLYPH_ROM [GLYPH_NUM] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700,
    40'h147F147F14, 40'h242A7F2A12, 40'h2313086462,
    40'h3649552250, 40'h0005030000, 40'h001C224100,
    40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000,
    40'h4261514946, 40'h2141454B31, 40'h1814127F10,
    40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000,
    40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E,
    40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901,
    40'h3E4149497A, 40'h7F0808087F, 40'h00417F4100,
    40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946,
    40'h4649494931, 40'h01017F0101, 40'h3F4040403F,
    40'h1F2040201F, 40'h3F4038403F, 40'h6314081463,
    40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204,
    40'h4040404040, 40'h0001020400, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F,
    40'h3854545418, 40'h087E090102, 40'h0C5252523E,
    40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478,
    40'h7C08040478, 40'h3844444438, 40'h7C14141408,
    40'h081414187C, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C,
    40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44
  };

  function automatic logic [GLYPH_ROWS-1:0] glyph_col(input logic [CODE_W-1:0] code,
                                                     input logic [GX_W-1:0] gx);
    logic [CODE_W-1:0] ofs;
    logic [39:0]       ent;
    logic [GLYPH_ROWS-1:0] bits;
    ofs  = code - FIRST_CODE;
    ent  = '0;
    bits = '0;
    if (code >= FIRST_CODE && code <= LAST_CODE) begin
      ent = GLYPH_ROM[ofs[6:0]];
    end
    case (gx)
      3'd0: bits = ent[38:32];
      3'd1: bits = ent[30:24];
      3'd2: bits = ent[22:16];
      3'd3: bits = ent[14:8];
      3'd4: bits = ent[6:0];
      default: bits = '0;
    endcase
    return bits;
  endfunction

endpackage

// ----- hw/rtl/tbpg_locate.sv -----
// scan position counters and the column to cell split stage
module tbpg_locate import tbpg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic              take_i,
  input  logic              action_i,
  input  logic [IDX_W-1:0]  char_index_i,
  input  logic [CODE_W-1:0] char_code_i,
  input  cfg_t              cfg_i,
  output loc_t              loc_o
);

  logic [COL_W-1:0]  scan_col_q, scan_col_d;
  logic [ROW_W-1:0]  scan_row_q, scan_row_d;
  logic              vld_q, emit_q, last_q, ge_q;
  logic [IDX_W-1:0]  idx_q;
  logic [CODE_W-1:0] code_q;
  logic [COL_W-1:0]  col_q, rel_q;
  logic [ROW_W-1:0]  row_q;
  logic [PROD_W-1:0] prod_q;

  logic [COL_W-1:0]  rel;
  logic [PROD_W-1:0] prod;
  logic              col_end, row_end;
  logic [CELL_W-1:0] slot;
  logic [COL_W-1:0]  gx_full;
  logic [ROW_W-1:0]  gy;
  logic [LEN_W-1:0]  len_eff;
  logic              draw;

  assign col_end = (scan_col_q == COL_W'(BAND_WIDTH - 1));
  assign row_end = (scan_row_q == ROW_W'(BAND_ROWS - 1));

  always_comb begin
    scan_col_d = scan_col_q;
    scan_row_d = scan_row_q;
    if (take_i && action_i) begin
      if (col_end) begin
        scan_col_d = '0;
        scan_row_d = row_end ? '0 : scan_row_q + 1'b1;
      end else begin
        scan_col_d = scan_col_q + 1'b1;
      end
    end
  end

  assign rel  = scan_col_q - cfg_i.margin;
  assign prod = PROD_W'(rel) * PROD_W'(RECIP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_col_q <= '0;
      scan_row_q <= '0;
      vld_q      <= 1'b0;
    end else begin
      scan_col_q <= scan_col_d;
      scan_row_q <= scan_row_d;
      if (adv_i) begin
        vld_q <= take_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      emit_q <= action_i;
      idx_q  <= char_index_i;
      code_q <= char_code_i;
      col_q  <= scan_col_q;
      row_q  <= scan_row_q;
      last_q <= col_end && row_end;
      ge_q   <= (scan_col_q >= cfg_i.margin);
      rel_q  <= rel;
      prod_q <= prod;
    end
  end

  assign slot    = prod_q[PROD_W-1:DIV_SHIFT];
  assign gx_full = rel_q - COL_W'(slot * CHAR_PITCH);
  assign gy      = row_q - cfg_i.row_off;
  assign len_eff = (cfg_i.length > LEN_W'(MAX_CHARS)) ? LEN_W'(MAX_CHARS) : cfg_i.length;

  assign draw = ge_q
             && (8'(slot) < 8'(len_eff))
             && (gx_full[GX_W-1:0] < GX_W'(GLYPH_COLS))
             && (row_q >= cfg_i.row_off)
             && (gy < ROW_W'(GLYPH_ROWS));

  always_comb begin
    loc_o.vld  = vld_q;
    loc_o.emit = emit_q;
    loc_o.idx  = idx_q;
    loc_o.code = code_q;
    loc_o.addr = slot[ADDR_W-1:0];
    loc_o.col  = col_q;
    loc_o.row  = row_q;
    loc_o.last = last_q;
    loc_o.draw = draw;
    loc_o.gx   = gx_full[GX_W-1:0];
    loc_o.gy   = gy;
  end

endmodule

// ----- hw/rtl/tbpg_lookup.sv -----
// text memory access and glyph dot lookup stage
module tbpg_lookup import tbpg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  loc_t loc_i,
  input  cfg_t cfg_i,
  output pix_t pix_o
);

  logic [CODE_W-1:0] mem_q [MAX_CHARS];
  logic [CODE_W-1:0] rd_q;
  logic              vld_q, last_q, draw_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;
  logic [GX_W-1:0]   gx_q;
  logic [ROW_W-1:0]  gy_q;

  logic              code_ok;
  logic [GLYPH_ROWS-1:0] bits;
  logic              dot;

  // reads and writes stay in item order, so a store is seen by every later emit
  always_ff @(posedge clk_i) begin
    if (adv_i && loc_i.vld) begin
      if (loc_i.emit) begin
        rd_q <= mem_q[loc_i.addr];
      end else if (8'(loc_i.idx) < 8'(MAX_CHARS)) begin
        mem_q[loc_i.idx[ADDR_W-1:0]] <= loc_i.code;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= loc_i.vld && loc_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      col_q  <= loc_i.col;
      row_q  <= loc_i.row;
      last_q <= loc_i.last;
      draw_q <= loc_i.draw;
      gx_q   <= loc_i.gx;
      gy_q   <= loc_i.gy;
    end
  end

  assign code_ok = rd_q inside {[FIRST_CODE:LAST_CODE]};
  assign bits    = glyph_col(rd_q, gx_q);
  assign dot     = (gy_q < ROW_W'(GLYPH_ROWS)) ? bits[gy_q] : 1'b0;

  always_comb begin
    pix_o.vld   = vld_q;
    pix_o.color = (draw_q && code_ok && dot) ? cfg_i.fg : cfg_i.bg;
    pix_o.col   = col_q;
    pix_o.row   = row_q;
    pix_o.last  = last_q;
  end

endmodule

// ----- hw/rtl/text_band_pixel_generator_top.sv -----
// top level of the text band pixel generator: handshakes, settings and output register
//
// channel   | transfer when                  | payload
// s_axis    | s_axis_tvalid & s_axis_tready  | tdata: char_index, char_code; tuser: action
// m_axis    | m_axis_tvalid & m_axis_tready  | tdata: pixel_color, pixel_column, pixel_row; tlast
// cfg       | cfg_valid_i & cfg_ready_o      | cfg_index_i, cfg_data_i
//
// one item per clock unless m_axis stalls; each emit is registered in locate, lookup, output
// the throughput is set by the single text memory port, one access per item
// reset clears the scan position and loads register defaults; no clearing pass
// a stalled output holds every stage, and s_axis_tready drops for that cycle
module text_band_pixel_generator_top import tbpg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,  // char_index, char_code, zero fill
  input  logic [0:0]            s_axis_tuser,  // action
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [31:0]           m_axis_tdata,  // pixel_color, pixel_column, pixel_row, zero fill
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t cfg_q, cfg_d;
  loc_t loc;
  pix_t pix;
  logic adv, take;
  logic               out_vld_q;
  logic [COLOR_W-1:0] out_color_q;
  logic [COL_W-1:0]   out_col_q;
  logic [ROW_W-1:0]   out_row_q;
  logic               out_last_q;

  assign adv           = !out_vld_q || m_axis_tready;
  assign take          = s_axis_tvalid && adv;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_FG_COLOR:   cfg_d.fg      = cfg_data_i;
        CFG_BG_COLOR:   cfg_d.bg      = cfg_data_i;
        CFG_ROW_OFFSET: cfg_d.row_off = cfg_data_i[ROW_W-1:0];
        CFG_MARGIN:     cfg_d.margin  = cfg_data_i[COL_W-1:0];
        CFG_LENGTH:     cfg_d.length  = cfg_data_i[LEN_W-1:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fg      <= FG_RESET;
      cfg_q.bg      <= BG_RESET;
      cfg_q.row_off <= ROW_OFF_RESET;
      cfg_q.margin  <= MARGIN_RESET;
      cfg_q.length  <= LENGTH_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tbpg_locate u_locate (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .take_i       (take),
    .action_i     (s_axis_tuser[0]),
    .char_index_i (s_axis_tdata[5:0]),
    .char_code_i  (s_axis_tdata[13:6]),
    .cfg_i        (cfg_q),
    .loc_o        (loc)
  );

  tbpg_lookup u_lookup (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .loc_i  (loc),
    .cfg_i  (cfg_q),
    .pix_o  (pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= pix.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_color_q <= pix.color;
      out_col_q   <= pix.col;
      out_row_q   <= pix.row;
      out_last_q  <= pix.last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0, out_row_q, out_col_q, out_color_q};
  assign m_axis_tlast  = out_last_q;

endmodule

// ----- hw/rtl/tbpg_checker.sv -----
// port level checks of the text band pixel generator and their bind
module tbpg_checker import tbpg_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [31:0]           m_axis_tdata,
  input logic                  m_axis_tlast
);

  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;

  assign out_col = m_axis_tdata[24:16];
  assign out_row = m_axis_tdata[27:25];

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output changed during a stall");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == ((out_col == COL_W'(BAND_WIDTH - 1))
      && (out_row == ROW_W'(BAND_ROWS - 1)))))
    else $error("tlast not on the final band pixel");

  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_col < COL_W'(BAND_WIDTH)))
    else $error("pixel column beyond the band");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind text_band_pixel_generator_top tbpg_checker u_tbpg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
